[rtl/bbmr_pkg.sv]
// Package for the bidirectional block motion refinement block.
// Shared types, constants and the search offset table; no dependencies.
package bbmr_pkg;

  localparam int RegionMax   = 32;
  localparam int PixelBits   = 16;
  localparam int WinSide     = RegionMax + 2;
  localparam int PredDepth   = RegionMax * RegionMax;
  localparam int WinDepth    = WinSide * WinSide;
  localparam int PredAw      = $clog2(PredDepth);
  localparam int WinAw       = $clog2(WinDepth);
  localparam int SideW       = $clog2(RegionMax + 1);
  localparam int CoordW      = $clog2(RegionMax);
  localparam int SadW        = 26;
  localparam int AccW        = SadW + 1;
  localparam int VecW        = 9;
  localparam int OutVecW     = 10;
  localparam int TagW        = 12;
  localparam int NumOffs     = 9;
  localparam int OffsW       = 4;
  localparam logic [SadW-1:0] SadMax = '1;

  typedef enum logic [1:0] {
    MODE_PRED = 2'd0,
    MODE_PREV = 2'd1,
    MODE_NEXT = 2'd2,
    MODE_SRCH = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SCAN  = 2'd1,
    ST_DRAIN = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [VecW-1:0]  py;
    logic [VecW-1:0]  px;
    logic [VecW-1:0]  ny;
    logic [VecW-1:0]  nx;
  } search_t;

  typedef struct packed {
    logic [TagW-1:0]    tag;
    logic [OutVecW-1:0] bpy;
    logic [OutVecW-1:0] bpx;
    logic [OutVecW-1:0] bny;
    logic [OutVecW-1:0] bnx;
    logic [SadW-1:0]    pmin;
    logic [SadW-1:0]    nmin;
  } result_t;

  // offset in {-1,0,1} as 2-bit signed
  function automatic logic signed [1:0] offs_y(input logic [OffsW-1:0] k);
    case (k)
      4'd0, 4'd1, 4'd4: offs_y = -2'sd1;
      4'd2, 4'd3, 4'd5: offs_y = 2'sd1;
      default:          offs_y = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] offs_x(input logic [OffsW-1:0] k);
    case (k)
      4'd0, 4'd2, 4'd7: offs_x = -2'sd1;
      4'd1, 4'd3, 4'd6: offs_x = 2'sd1;
      default:          offs_x = 2'sd0;
    endcase
  endfunction

endpackage

[rtl/bidir_block_motion_refine.sv]
// Top level of the bidirectional block motion refinement block.
// Depends on bbmr_pkg, bbmr_front and bbmr_back.
//
// Usage: requests arrive on the in_ stream. Loads (tuser mode 0..2) write one
// pixel into the predicted store or one of the two windows, one per cycle.
// A search (mode 3) enters a two-entry queue; the back end then scans the
// region nine times, one pixel per cycle, and emits one result on out_.
// A search passes from the queue through the scan, the drain of the read stage
// and the result register to out_tvalid (side = region_side, clamped to 1..32);
// the single read port of each store means one search is scanned at a time.
// Loads stream at one per cycle while no search waits or scans; behind a
// search in_tready drops for a load until the scan is over, and for a search
// while the queue is full.
// Reset (synchronous, rst_n low) empties the queue and result register and
// sets region_side to 16; store contents are undefined until written.
// When out_tready is low the result is held and later searches wait.
// region_side is written through the cfg_ APB port at address 0.
module bidir_block_motion_refine import bbmr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // mode
  input  logic [1:0]  in_tuser,
  // pixel_row, pixel_col, pixel_value, init_prev_y, init_prev_x,
  // init_next_y, init_next_x, block_tag (pad to 80 bits)
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // result_tag, best_prev_y, best_prev_x, best_next_y, best_next_x,
  // prev_min_sad, next_min_sad (pad to 112 bits)
  output logic [111:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [5:0] side_cfg_r;
  logic [SideW-1:0] side;
  search_t srch;
  logic pred_we, prev_we, next_we, q_valid, q_pop, scan_busy;
  logic [PredAw-1:0] pred_wa;
  logic [WinAw-1:0] win_wa;
  logic [PixelBits-1:0] wdata;
  search_t q_data;
  result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {26'd0, side_cfg_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) side_cfg_r <= 6'd16;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      side_cfg_r <= cfg_pwdata[5:0];
  end

  assign side = (side_cfg_r == 6'd0) ? SideW'(1) :
                (32'(side_cfg_r) > RegionMax) ? SideW'(RegionMax) : SideW'(side_cfg_r);

  assign srch = '{tag: in_tdata[75:64], py: in_tdata[36:28], px: in_tdata[45:37],
                  ny: in_tdata[54:46], nx: in_tdata[63:55]};

  bbmr_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .mode(in_tuser),
    .row(in_tdata[5:0]), .col(in_tdata[11:6]), .value(in_tdata[27:12]),
    .srch_in(srch), .back_busy(scan_busy), .pred_we, .pred_wa, .prev_we, .next_we,
    .win_wa, .wdata, .q_valid, .q_pop, .q_data
  );

  bbmr_back u_back (
    .clk, .rst_n, .side, .pred_we, .pred_wa, .prev_we, .next_we, .win_wa, .wdata,
    .q_valid, .q_pop, .q_data, .scan_busy, .res_valid(out_tvalid),
    .res_ready(out_tready), .res
  );

  assign out_tdata = {8'd0, res.nmin, res.pmin, res.bnx, res.bny,
                      res.bpx, res.bpy, res.tag};

endmodule

[rtl/bbmr_front.sv]
// Front part: accepts requests, writes loads into the stores, queues searches.
// Depends on bbmr_pkg.
module bbmr_front import bbmr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      mode,
  input  logic [5:0]      row,
  input  logic [5:0]      col,
  input  logic [15:0]     value,
  input  search_t         srch_in,
  input  logic            back_busy,
  output logic            pred_we,
  output logic [PredAw-1:0] pred_wa,
  output logic            prev_we,
  output logic            next_we,
  output logic [WinAw-1:0] win_wa,
  output logic [PixelBits-1:0] wdata,
  output logic            q_valid,
  input  logic            q_pop,
  output search_t         q_data
);

  // two-entry search queue
  search_t     q_mem_r [2];
  logic [1:0]  q_cnt_r, q_cnt_nxt;
  logic        q_wp_r, q_rp_r;
  logic        push, acc;

  // hold loads back while a search waits or scans, so it sees the stores as they were
  assign in_ready = (mode == MODE_SRCH) ? (q_cnt_r != 2'd2) :
                    (q_cnt_r == 2'd0 && !back_busy);
  assign acc      = in_valid && in_ready;
  assign push     = acc && (mode == MODE_SRCH);

  assign wdata   = value[PixelBits-1:0];
  assign pred_wa = PredAw'({row[CoordW-1:0], col[CoordW-1:0]});
  assign win_wa  = WinAw'(row * 6'(WinSide) + 11'(col));
  assign pred_we = acc && mode == MODE_PRED && row < RegionMax && col < RegionMax;
  assign prev_we = acc && mode == MODE_PREV && row < WinSide && col < WinSide;
  assign next_we = acc && mode == MODE_NEXT && row < WinSide && col < WinSide;

  assign q_valid = (q_cnt_r != 2'd0);
  assign q_data  = q_mem_r[q_rp_r];

  always_comb begin
    q_cnt_nxt = q_cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (push) q_wp_r <= ~q_wp_r;
      if (q_pop) q_rp_r <= ~q_rp_r;
    end
    if (push) q_mem_r[q_wp_r] <= srch_in;
  end

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n) q_cnt_r != 2'd3)
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r == 2'd2 |-> !in_ready) else $error("accept while full");
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (pred_we || prev_we || next_we) |-> !back_busy && !q_valid)
    else $error("load during search");

endmodule

[rtl/bbmr_back.sv]
// Back part: walks nine offsets over the region, accumulates both SADs.
// Depends on bbmr_pkg; holds the pixel stores as memories.
module bbmr_back import bbmr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [SideW-1:0] side,
  input  logic            pred_we,
  input  logic [PredAw-1:0] pred_wa,
  input  logic            prev_we,
  input  logic            next_we,
  input  logic [WinAw-1:0] win_wa,
  input  logic [PixelBits-1:0] wdata,
  input  logic            q_valid,
  output logic            q_pop,
  input  search_t         q_data,
  output logic            scan_busy,
  output logic            res_valid,
  input  logic            res_ready,
  output result_t         res
);

  logic signed [PixelBits-1:0] pred_mem [PredDepth];
  logic signed [PixelBits-1:0] prev_mem [WinDepth];
  logic signed [PixelBits-1:0] next_mem [WinDepth];

  state_t state_r, state_nxt;
  search_t job_r;
  logic [OffsW-1:0]  k_r;
  logic [CoordW-1:0] r_r, c_r;
  logic              last_pix, last_k;
  logic [AccW-1:0]   pacc_r, nacc_r;
  logic [SadW-1:0]   pmin_r, nmin_r;
  logic [OutVecW-1:0] bpy_r, bpx_r, bny_r, bnx_r;
  // read stage
  logic              rd_v_r, rd_last_r;
  logic [OffsW-1:0]  rd_k_r;
  logic signed [PixelBits-1:0] p_q_r, pv_q_r, nv_q_r;
  logic [PredAw-1:0] p_ra;
  logic [WinAw-1:0]  pv_ra, nv_ra;
  logic [6:0]        wr_p, wc_p, wr_n, wc_n;
  logic signed [PixelBits:0] dp, dn;
  logic [PixelBits-1:0] adp, adn;
  logic [AccW-1:0]   ps_full, ns_full;
  logic [SadW-1:0]   ps, ns;
  logic              scan_en;
  result_t           res_r;
  logic              res_v_r;

  assign last_pix = (32'(r_r) == 32'(side) - 1) && (32'(c_r) == 32'(side) - 1);
  assign last_k   = (k_r == OffsW'(NumOffs - 1));
  assign scan_en  = (state_r == ST_SCAN);
  assign scan_busy = scan_en;

  // window index (r+1+dy)*WinSide + (c+1+dx), forward uses mirrored offset
  always_comb begin
    wr_p  = 7'(7'(r_r) + 7'sd1 + 7'(offs_y(k_r)));
    wc_p  = 7'(7'(c_r) + 7'sd1 + 7'(offs_x(k_r)));
    wr_n  = 7'(7'(r_r) + 7'sd1 - 7'(offs_y(k_r)));
    wc_n  = 7'(7'(c_r) + 7'sd1 - 7'(offs_x(k_r)));
    p_ra  = PredAw'({r_r, c_r});
    pv_ra = WinAw'(wr_p * 7'(WinSide) + 11'(wc_p));
    nv_ra = WinAw'(wr_n * 7'(WinSide) + 11'(wc_n));
  end

  always_ff @(posedge clk) begin
    if (pred_we) pred_mem[pred_wa] <= wdata;
    if (prev_we) prev_mem[win_wa] <= wdata;
    if (next_we) next_mem[win_wa] <= wdata;
    p_q_r  <= pred_mem[p_ra];
    pv_q_r <= prev_mem[pv_ra];
    nv_q_r <= next_mem[nv_ra];
  end

  always_comb begin
    dp  = (PixelBits+1)'(p_q_r) - (PixelBits+1)'(pv_q_r);
    dn  = (PixelBits+1)'(p_q_r) - (PixelBits+1)'(nv_q_r);
    adp = PixelBits'(dp[PixelBits] ? -dp : dp);
    adn = PixelBits'(dn[PixelBits] ? -dn : dn);
    ps_full = pacc_r + AccW'(adp);
    ns_full = nacc_r + AccW'(adn);
    ps = ps_full[SadW] ? SadMax : ps_full[SadW-1:0];
    ns = ns_full[SadW] ? SadMax : ns_full[SadW-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (last_pix && last_k) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!rd_v_r) state_nxt = ST_OUT;
      ST_OUT:   if (!res_v_r || res_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rd_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= scan_en;
      if (state_r == ST_OUT && (!res_v_r || res_ready)) res_v_r <= 1'b1;
      else if (res_ready) res_v_r <= 1'b0;
    end
    rd_last_r <= last_pix;
    rd_k_r    <= k_r;
    if (q_pop) begin
      job_r <= q_data;
      k_r <= '0; r_r <= '0; c_r <= '0;
      pacc_r <= '0; nacc_r <= '0;
    end else if (scan_en) begin
      if (last_pix) begin
        r_r <= '0; c_r <= '0; k_r <= k_r + 1'b1;
      end else if (32'(c_r) == 32'(side) - 1) begin
        c_r <= '0; r_r <= r_r + 1'b1;
      end else begin
        c_r <= c_r + 1'b1;
      end
    end
    if (rd_v_r) begin
      if (rd_last_r) begin
        pacc_r <= '0; nacc_r <= '0;
        // ties go to the later candidate
        if (rd_k_r == '0 || ps <= pmin_r) begin
          pmin_r <= ps;
          bpy_r <= OutVecW'($signed(job_r.py)) + OutVecW'(offs_y(rd_k_r));
          bpx_r <= OutVecW'($signed(job_r.px)) + OutVecW'(offs_x(rd_k_r));
        end
        if (rd_k_r == '0 || ns <= nmin_r) begin
          nmin_r <= ns;
          bny_r <= OutVecW'($signed(job_r.ny)) - OutVecW'(offs_y(rd_k_r));
          bnx_r <= OutVecW'($signed(job_r.nx)) - OutVecW'(offs_x(rd_k_r));
        end
      end else begin
        pacc_r <= AccW'(ps);
        nacc_r <= AccW'(ns);
      end
    end
    if (state_r == ST_OUT && (!res_v_r || res_ready)) begin
      res_r <= '{tag: job_r.tag, bpy: bpy_r, bpx: bpx_r, bny: bny_r, bnx: bnx_r,
                 pmin: pmin_r, nmin: nmin_r};
    end
  end

  assign res_valid = res_v_r;
  assign res       = res_r;

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ST_SCAN) else $error("pop did not start scan");
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> !rd_v_r) else $error("result before drain");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r && !res_ready |=> res_v_r) else $error("result dropped");

endmodule

[verif/bidir_block_motion_refine_test.sv]
// Self-checking testbench for bidir_block_motion_refine: stream requests in,
// refined vectors out, region side set through the APB port.
// Depends on bbmr_pkg and the block's RTL only.
module bidir_block_motion_refine_test;
  import bbmr_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = 30;

  typedef struct {
    mode_t mode;
    logic [5:0] row;
    logic [5:0] col;
    logic [15:0] value;
    logic [8:0] py, px, ny, nx;
    logic [11:0] tag;
  } motion_req_t;

  typedef struct {
    logic [11:0] tag;
    logic [9:0] bpy, bpx, bny, bnx;
    logic [25:0] pmin, nmin;
  } refine_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [1:0] in_tuser = MODE_PRED;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  bidir_block_motion_refine dut (.*);

  // predictor state
  logic signed [15:0] pred_pix [RegionMax][RegionMax];
  logic signed [15:0] bwd_win [WinSide][WinSide];
  logic signed [15:0] fwd_win [WinSide][WinSide];
  int side_reg = 16;

  // which entries the stimulus has already loaded
  bit pred_loaded [RegionMax][RegionMax];
  bit bwd_loaded [WinSide][WinSide];
  bit fwd_loaded [WinSide][WinSide];

  motion_req_t req_q[$];
  refine_res_t refine_q[$];
  motion_req_t cur_req;
  int snd_idle = 0, rcv_stall = 0;
  logic hold_req = 1'b0;
  logic hold_seen;
  int hold_left;
  int errors = 0, n_loads = 0, n_searches = 0, n_results = 0, cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint region_sad(bit fwd, int side, int dy, int dx);
    longint sum;
    longint d;
    sum = 0;
    for (int r = 0; r < side; r++) begin
      for (int c = 0; c < side; c++) begin
        if (fwd) d = longint'(pred_pix[r][c]) - longint'(fwd_win[r+1+dy][c+1+dx]);
        else     d = longint'(pred_pix[r][c]) - longint'(bwd_win[r+1+dy][c+1+dx]);
        sum += (d < 0) ? -d : d;
      end
    end
    return (sum > 67108863) ? 67108863 : sum;
  endfunction

  task automatic predict_refine(motion_req_t q);
    int side;
    int dy, dx;
    int by, bx, fy, fx;
    longint bs, fs, bmin, fmin;
    refine_res_t res;
    int oy[9] = '{-1, -1, 1, 1, -1, 1, 0, 0, 0};
    int ox[9] = '{-1, 1, -1, 1, 0, 0, 1, -1, 0};
    if (q.mode != MODE_SRCH) begin
      n_loads++;
      if (q.mode == MODE_PRED) begin
        if (q.row < RegionMax && q.col < RegionMax) pred_pix[q.row][q.col] = q.value;
      end else if (q.row < WinSide && q.col < WinSide) begin
        if (q.mode == MODE_PREV) bwd_win[q.row][q.col] = q.value;
        else fwd_win[q.row][q.col] = q.value;
      end
      return;
    end
    n_searches++;
    side = side_reg;
    if (side < 1) side = 1;
    if (side > RegionMax) side = RegionMax;
    bmin = 0; fmin = 0; by = 0; bx = 0; fy = 0; fx = 0;
    for (int k = 0; k < 9; k++) begin
      dy = oy[k];
      dx = ox[k];
      bs = region_sad(1'b0, side, dy, dx);
      fs = region_sad(1'b1, side, -dy, -dx);
      // later candidate wins on a tie
      if (k == 0 || bs <= bmin) begin
        bmin = bs;
        by = int'($signed(q.py)) + dy;
        bx = int'($signed(q.px)) + dx;
      end
      if (k == 0 || fs <= fmin) begin
        fmin = fs;
        fy = int'($signed(q.ny)) - dy;
        fx = int'($signed(q.nx)) - dx;
      end
    end
    res.tag = q.tag;
    res.bpy = by[9:0];
    res.bpx = bx[9:0];
    res.bny = fy[9:0];
    res.bnx = fx[9:0];
    res.pmin = bmin[25:0];
    res.nmin = fmin[25:0];
    refine_q.push_back(res);
  endtask

  // driver: loads wait until every search in flight has answered
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_refine(cur_req);
      if (!in_tvalid || in_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= snd_idle &&
            (req_q[0].mode == MODE_SRCH || refine_q.size() == 0)) begin
          cur_req = req_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.mode;
          in_tdata <= {4'b0, cur_req.tag, cur_req.nx, cur_req.ny, cur_req.px, cur_req.py,
                       cur_req.value, cur_req.col, cur_req.row};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_left <= 3000;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // monitor
  always @(posedge clk) begin
    refine_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (refine_q.size() == 0) begin
        $error("result with no search outstanding: %h", out_tdata);
        errors++;
      end else begin
        e = refine_q.pop_front();
        if (out_tdata[11:0] !== e.tag) begin
          $error("result_tag exp %0d got %0d", e.tag, out_tdata[11:0]); errors++;
        end
        if (out_tdata[21:12] !== e.bpy) begin
          $error("best_prev_y exp %0d got %0d", $signed(e.bpy), $signed(out_tdata[21:12]));
          errors++;
        end
        if (out_tdata[31:22] !== e.bpx) begin
          $error("best_prev_x exp %0d got %0d", $signed(e.bpx), $signed(out_tdata[31:22]));
          errors++;
        end
        if (out_tdata[41:32] !== e.bny) begin
          $error("best_next_y exp %0d got %0d", $signed(e.bny), $signed(out_tdata[41:32]));
          errors++;
        end
        if (out_tdata[51:42] !== e.bnx) begin
          $error("best_next_x exp %0d got %0d", $signed(e.bnx), $signed(out_tdata[51:42]));
          errors++;
        end
        if (out_tdata[77:52] !== e.pmin) begin
          $error("prev_min_sad exp %0d got %0d", e.pmin, out_tdata[77:52]); errors++;
        end
        if (out_tdata[103:78] !== e.nmin) begin
          $error("next_min_sad exp %0d got %0d", e.nmin, out_tdata[103:78]); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_load(mode_t m, int r, int c, logic [15:0] v);
    motion_req_t q;
    q = '{mode: m, row: r[5:0], col: c[5:0], value: v,
          py: 9'($urandom), px: 9'($urandom), ny: 9'($urandom), nx: 9'($urandom),
          tag: 12'($urandom)};
    if (m == MODE_PRED && r < RegionMax && c < RegionMax) pred_loaded[r][c] = 1'b1;
    if (m == MODE_PREV && r < WinSide && c < WinSide) bwd_loaded[r][c] = 1'b1;
    if (m == MODE_NEXT && r < WinSide && c < WinSide) fwd_loaded[r][c] = 1'b1;
    req_q.push_back(q);
  endtask

  task automatic push_search(logic [8:0] py, logic [8:0] px, logic [8:0] ny, logic [8:0] nx,
                             logic [11:0] tag);
    motion_req_t q;
    q = '{mode: MODE_SRCH, row: 6'($urandom), col: 6'($urandom), value: 16'($urandom),
          py: py, px: px, ny: ny, nx: nx, tag: tag};
    req_q.push_back(q);
  endtask

  task automatic push_rand_search();
    push_search(9'($urandom), 9'($urandom), 9'($urandom), 9'($urandom), 12'($urandom));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (req_q.size() != 0 || refine_q.size() != 0 || in_tvalid);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_side(int v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 2'd0;
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    side_reg = v & 63;
  endtask

  // load every entry a search at this side reads that has not been loaded yet
  task automatic fill_region(int s);
    for (int r = 0; r < s + 2; r++) begin
      for (int c = 0; c < s + 2; c++) begin
        if (r < s && c < s && !pred_loaded[r][c]) push_load(MODE_PRED, r, c, 16'($urandom));
        if (!bwd_loaded[r][c]) push_load(MODE_PREV, r, c, 16'($urandom));
        if (!fwd_loaded[r][c]) push_load(MODE_NEXT, r, c, 16'($urandom));
      end
    end
  endtask

  task automatic run_phase(int side_val, int idle_kind, int groups, int max_srch);
    int s, lim;
    mode_t m;
    s = (side_val < 1) ? 1 : (side_val > RegionMax ? RegionMax : side_val);
    write_side(side_val);
    case (idle_kind)
      0: begin snd_idle = 0;  rcv_stall = 0;  end
      1: begin snd_idle = 45; rcv_stall = 0;  end
      2: begin snd_idle = 0;  rcv_stall = 45; end
      default: begin snd_idle = 35; rcv_stall = 35; end
    endcase
    fill_region(s);
    for (int g = 0; g < groups; g++) begin
      repeat ($urandom_range(6)) begin
        m = mode_t'($urandom_range(2));
        lim = (m == MODE_PRED) ? s - 1 : s + 1;
        if ($urandom_range(4) == 0)
          push_load(m, $urandom_range(63), $urandom_range(63), 16'($urandom));
        else push_load(m, $urandom_range(lim), $urandom_range(lim), 16'($urandom));
      end
      repeat ($urandom_range(max_srch, 1)) push_rand_search();
    end
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-pixel region with extreme values, ignored loads, a full tie on forward
    write_side(1);
    push_load(MODE_PRED, 0, 0, 16'h8000);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_load(MODE_PREV, r, c, ((r + c) % 2) ? 16'h7fff : 16'h8000);
        push_load(MODE_NEXT, r, c, 16'd100);
      end
    end
    push_load(MODE_PRED, 32, 5, 16'h1234);
    push_load(MODE_PREV, 34, 0, 16'h7fff);
    push_load(MODE_NEXT, 0, 63, 16'h7fff);
    push_search(9'd255, 9'h100, 9'h101, 9'd0, 12'hfff);
    push_search(9'h100, 9'd255, 9'd0, 9'h1ff, 12'h000);
    wait_idle();

    run_phase(2, 0, 30, 3);
    run_phase(0, 1, 30, 3);
    run_phase(3, 2, 30, 3);
    run_phase(5, 3, 20, 2);
    run_phase(10, 0, 3, 2);
    run_phase(7, 1, 15, 2);

    // receiver holds off while searches keep coming, until the input backs up
    write_side(4);
    snd_idle = 0;
    rcv_stall = 0;
    fill_region(4);
    wait_idle();
    hold_req <= 1'b1;
    repeat (8) push_rand_search();
    wait_idle();

    run_phase(1, 2, 30, 3);
    run_phase(6, 3, 20, 3);
    run_phase(2, 2, 30, 2);

    repeat (SettleCycles) @(posedge clk);
    $display("Covered %0d loads and %0d searches (%0d results) over region sides 0..10,",
             n_loads, n_searches, n_results);
    $display("with sender gaps, receiver stalls and a long receiver hold-off.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[bidir_block_motion_refine.f]
rtl/bbmr_pkg.sv
rtl/bbmr_front.sv
rtl/bbmr_back.sv
rtl/bidir_block_motion_refine.sv
verif/bidir_block_motion_refine_test.sv
